// ===== rtl/core/rmst_pkg.sv =====
// rmst_pkg: shared types and constants for the range-maximum segment tree
// holds field widths, opcodes, register map and controller/datapath structs
// no dependencies
package rmst_pkg;

    // field widths fixed by the interface
    localparam int DATA_W  = 32;
    localparam int IDX_W   = 10;
    localparam int COUNT_W = 11;

    // most negative element value, returned for empty ranges
    localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // register map, apb word select
    localparam int              APB_ADDR_W        = 3;
    localparam int              APB_DATA_W        = 32;
    localparam logic            REG_ELEMENT_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] COUNT_RESET    = 11'd1024;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;     // latch a new transaction
        logic leaf_write;  // write the loaded leaf, read its sibling
        logic climb;       // write one parent, read the next sibling
        logic walk;        // issue reads for one query level
        logic gather;      // fold last cycle's read data into the maximum
    } rmst_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_query;     // incoming transaction is a query
        logic load_skip;    // incoming load index is out of range
        logic query_empty;  // incoming query range is empty after clipping
        logic at_root;      // the current climb step writes the root
        logic walk_last;    // the current walk step is the last level
    } rmst_status_t;

endpackage

// ===== rtl/core/rmst_ram.sv =====
// rmst_ram: generic one-write, two-read ram with registered read data
// depends on nothing
module rmst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

// ===== rtl/core/rmst_ctrl.sv =====
// rmst_ctrl: controller state machine for the range-maximum segment tree
// depends on rmst_pkg (command and status structs)
module rmst_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  rmst_pkg::rmst_status_t status,
    output rmst_pkg::rmst_cmd_t    cmd,
    output logic                  busy,
    output logic                  done
);
    import rmst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEAF,
        S_CLIMB,
        S_WALK,
        S_GATHER
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    // next state and datapath commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    if (status.is_query)
                    begin
                        if (status.query_empty)
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    else if (!status.load_skip)
                    begin
                        state_next = S_LEAF;
                    end
                end
            end
            S_LEAF:
            begin
                cmd.leaf_write = 1'b1;
                state_next     = S_CLIMB;
            end
            S_CLIMB:
            begin
                cmd.climb = 1'b1;
                if (status.at_root)
                begin
                    state_next = S_IDLE;
                end
            end
            S_WALK:
            begin
                cmd.walk   = 1'b1;
                cmd.gather = 1'b1;
                if (status.walk_last)
                begin
                    state_next = S_GATHER;
                end
            end
            S_GATHER:
            begin
                cmd.gather = 1'b1;
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

// ===== rtl/core/rmst_datapath.sv =====
// rmst_datapath: node pointers, running maxima and the tree memory
// depends on rmst_pkg and rmst_ram
module rmst_datapath #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                                  clk,
    input  rmst_pkg::rmst_cmd_t                    cmd,
    output rmst_pkg::rmst_status_t                 status,
    input  logic [rmst_pkg::COUNT_W-1:0]           element_count,
    input  logic                                  opcode,
    input  logic [rmst_pkg::IDX_W-1:0]             element_index,
    input  logic signed [rmst_pkg::DATA_W-1:0]     element_value,
    input  logic [rmst_pkg::IDX_W-1:0]             range_start,
    input  logic [rmst_pkg::IDX_W-1:0]             range_end,
    output logic signed [rmst_pkg::DATA_W-1:0]     range_maximum,
    output logic                                  range_empty
);
    import rmst_pkg::*;

    localparam int NODES = 2 * MAX_ELEMENTS;
    localparam int AW    = $clog2(NODES);
    localparam int PW    = $clog2(NODES + 1);
    localparam int CW    = ($clog2(MAX_ELEMENTS + 1) > COUNT_W) ?
                           $clog2(MAX_ELEMENTS + 1) : COUNT_W;
    localparam logic [CW-1:0] CAP  = CW'(MAX_ELEMENTS);
    localparam logic [PW-1:0] BASE = PW'(MAX_ELEMENTS);
    localparam logic [PW-1:0] ROOT = PW'(1);

    logic [CW-1:0] count_ext;
    logic [CW-1:0] cnt;
    logic [CW-1:0] idx_ext;
    logic [CW-1:0] start_ext;
    logic [CW-1:0] end_ext;
    logic [CW-1:0] end_clip;

    logic [PW-1:0]            lo_reg;
    logic [PW-1:0]            hi_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] best_reg;
    logic                     empty_reg;
    logic                     take_a_reg;
    logic                     take_b_reg;

    logic [PW-1:0]            parent;
    logic [PW-1:0]            sib_up;
    logic [PW-1:0]            sib_leaf;
    logic [PW-1:0]            lo_step;
    logic [PW-1:0]            hi_step;
    logic [PW-1:0]            hi_last;
    logic signed [DATA_W-1:0] up_max;
    logic signed [DATA_W-1:0] fold_a;
    logic signed [DATA_W-1:0] fold_b;

    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic [AW-1:0]            rd_addr_a;
    logic [AW-1:0]            rd_addr_b;
    logic [DATA_W-1:0]        rd_data_a;
    logic [DATA_W-1:0]        rd_data_b;

    // count in use and range clipping on the incoming transaction
    always_comb
    begin
        count_ext = CW'(element_count);
        cnt       = (count_ext > CAP) ? CAP : count_ext;
        idx_ext   = CW'(element_index);
        start_ext = CW'(range_start);
        end_ext   = CW'(range_end);
        end_clip  = (end_ext >= cnt) ? (cnt - CW'(1)) : end_ext;
    end

    // tree walk arithmetic
    always_comb
    begin
        parent   = lo_reg >> 1;
        sib_up   = parent ^ ROOT;
        sib_leaf = lo_reg ^ ROOT;
        lo_step  = (lo_reg + PW'(lo_reg[0])) >> 1;
        hi_step  = (hi_reg - PW'(hi_reg[0])) >> 1;
        hi_last  = hi_reg - ROOT;
        up_max   = ($signed(rd_data_a) > val_reg) ? $signed(rd_data_a) : val_reg;
        fold_a   = (take_a_reg && ($signed(rd_data_a) > best_reg)) ?
                   $signed(rd_data_a) : best_reg;
        fold_b   = (take_b_reg && ($signed(rd_data_b) > fold_a)) ?
                   $signed(rd_data_b) : fold_a;
    end

    // status to the controller
    always_comb
    begin
        status.is_query    = (opcode == OP_QUERY);
        status.load_skip   = (idx_ext >= cnt);
        status.query_empty = (cnt == '0) || (start_ext >= cnt) || (start_ext > end_clip);
        status.at_root     = (parent == ROOT);
        status.walk_last   = (lo_step >= hi_step);
    end

    // memory port selection
    always_comb
    begin
        wr_en   = cmd.leaf_write | cmd.climb;
        wr_addr = cmd.climb ? parent[AW-1:0] : lo_reg[AW-1:0];
        wr_data = cmd.climb ? up_max : val_reg;
        priority if (cmd.walk)
        begin
            rd_addr_a = lo_reg[AW-1:0];
        end
        else if (cmd.climb)
        begin
            rd_addr_a = sib_up[AW-1:0];
        end
        else
        begin
            rd_addr_a = sib_leaf[AW-1:0];
        end
        rd_addr_b = hi_last[AW-1:0];
    end

    // pointer, value and maximum registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            val_reg    <= element_value;
            best_reg   <= INT_MIN;
            empty_reg  <= status.query_empty;
            take_a_reg <= 1'b0;
            take_b_reg <= 1'b0;
            if (status.is_query)
            begin
                lo_reg <= PW'(range_start) + BASE;
                hi_reg <= PW'(end_clip) + BASE + ROOT;
            end
            else
            begin
                lo_reg <= PW'(element_index) + BASE;
            end
        end
        else
        begin
            if (cmd.climb)
            begin
                val_reg <= up_max;
                lo_reg  <= parent;
            end
            if (cmd.walk)
            begin
                lo_reg     <= lo_step;
                hi_reg     <= hi_step;
                take_a_reg <= lo_reg[0];
                take_b_reg <= hi_reg[0];
            end
            if (cmd.gather)
            begin
                best_reg <= fold_b;
            end
        end
    end

    // tree node storage
    rmst_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NODES)
    ) u_tree (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    assign range_maximum = best_reg;
    assign range_empty   = empty_reg;

endmodule

// ===== rtl/core/range_max_segment_tree.sv =====
// range_max_segment_tree: top level of the range-maximum segment tree
// depends on rmst_pkg, rmst_ctrl and rmst_datapath
//
// channel   direction  handshake                  payload
// command   in         start, busy                opcode, element_index, element_value,
//                                                 range_start, range_end
// result    out        done (one-cycle strobe)    range_maximum, range_empty
// config    in/out     apb psel/penable/pready    element_count at byte 0
//
// a load, from accept to the next accept, is one leaf write, then one parent write
// per tree level, one write at a time on the single write port of the node
// memory; an ignored load leaves the controller idle
// a query walks one tree level per cycle (at most log2(MAX_ELEMENTS) + 1 levels)
// with both ends read on the two memory read ports, then a final fold step; done
// follows; an empty query gives done in the cycle after accept
// node memory needs no clearing pass; after reset element_count is 1024
// results cannot be stalled: done is high for exactly one cycle per query
module range_max_segment_tree #(
    parameter int MAX_ELEMENTS = 1024
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  opcode,
    input  logic [rmst_pkg::IDX_W-1:0]             element_index,
    input  logic signed [rmst_pkg::DATA_W-1:0]     element_value,
    input  logic [rmst_pkg::IDX_W-1:0]             range_start,
    input  logic [rmst_pkg::IDX_W-1:0]             range_end,
    output logic                                  done,
    output logic signed [rmst_pkg::DATA_W-1:0]     range_maximum,
    output logic                                  range_empty,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rmst_pkg::APB_ADDR_W-1:0]        paddr,
    input  logic [rmst_pkg::APB_DATA_W-1:0]        pwdata,
    output logic [rmst_pkg::APB_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import rmst_pkg::*;

    logic [COUNT_W-1:0] element_count_reg;
    logic               cfg_write;
    rmst_cmd_t          cmd;
    rmst_status_t       status;

    // configuration register
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_count_reg <= COUNT_RESET;
        end
        else if (cfg_write)
        begin
            element_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ELEMENT_COUNT) ? APB_DATA_W'(element_count_reg) : '0;

    // controller
    rmst_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // datapath with node memory
    rmst_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk           (clk),
        .cmd           (cmd),
        .status        (status),
        .element_count (element_count_reg),
        .opcode        (opcode),
        .element_index (element_index),
        .element_value (element_value),
        .range_start   (range_start),
        .range_end     (range_end),
        .range_maximum (range_maximum),
        .range_empty   (range_empty)
    );

    // a load transaction never produces a result right after accept
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == OP_LOAD)) |=> !done)
        else $error("result strobe after a load transaction");

    // a result is only given once the controller is back at idle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an empty result carries the most negative value
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && range_empty) |-> (range_maximum == INT_MIN))
        else $error("empty result without the most negative value");

endmodule
